/* hw/rtl/sgt_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the set span tracker.
// No dependencies.

package sgt_pkg;

    localparam int SPAN_BITS  = 32;
    localparam int COUNT_BITS = 11;
    localparam int CAP_BITS   = 11;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 11'd1024;

    // status codes of a result beat
    localparam logic STATUS_STORED = 1'b0;
    localparam logic STATUS_FULL   = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_WRITE = 5'b01000,
        S_FIN   = 5'b10000
    } sgt_state_t;

endpackage

/* hw/rtl/sgt_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module sgt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/sgt_gap_unit.sv */
`timescale 1ns / 1ps
// Shared gap unit: absolute difference of new value against one stored value
// per cycle, then running minimum. Depends on sgt_pkg.

module sgt_gap_unit #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample,
    input  logic [VALUE_BITS-1:0]        new_value,
    input  logic [VALUE_BITS-1:0]        old_value,
    output logic                         busy,
    output logic [sgt_pkg::SPAN_BITS-1:0] gap
);

    logic signed [VALUE_BITS:0]    a_ext;
    logic signed [VALUE_BITS:0]    b_ext;
    logic signed [VALUE_BITS:0]    d_ab;
    logic signed [VALUE_BITS:0]    d_ba;
    logic [VALUE_BITS-1:0]         diff_next;
    logic [VALUE_BITS-1:0]         diff_reg;
    logic                          diff_vld_reg;
    logic [sgt_pkg::SPAN_BITS-1:0] diff_wide;
    logic [sgt_pkg::SPAN_BITS-1:0] gap_reg;

    assign a_ext = {new_value[VALUE_BITS-1], new_value};
    assign b_ext = {old_value[VALUE_BITS-1], old_value};
    assign d_ab  = a_ext - b_ext;
    assign d_ba  = b_ext - a_ext;
    // magnitude always fits in VALUE_BITS unsigned
    assign diff_next = d_ab[VALUE_BITS] ? d_ba[VALUE_BITS-1:0] : d_ab[VALUE_BITS-1:0];
    assign diff_wide = sgt_pkg::SPAN_BITS'(diff_reg);

    always_ff @(posedge clk)
    begin
        if (sample)
        begin
            diff_reg <= diff_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_vld_reg <= 1'b0;
            gap_reg      <= '1;
        end
        else
        begin
            diff_vld_reg <= sample;
            if (diff_vld_reg && (diff_wide < gap_reg))
            begin
                gap_reg <= diff_wide;
            end
        end
    end

    assign busy = diff_vld_reg;
    assign gap  = gap_reg;

endmodule

/* hw/rtl/set_min_max_gap_tracker_unit.sv */
`timescale 1ns / 1ps
// Top level of the set span tracker: sequencer, value store, min/max, result register.
// Depends on sgt_pkg, sgt_ram, sgt_gap_unit.

// Each input beat offers one signed number. If fewer numbers are held than
// min(capacity register, CAPACITY), the number is compared against every
// stored number, one stored entry per cycle through a single shared
// difference/minimum unit, then written to the store; otherwise it is
// rejected with status 1. One result beat follows each input beat with the
// count and, once two or more numbers are held, the shortest span (smallest
// pairwise difference) and longest span (max minus min). With N >= 1 numbers
// already held, a stored item passes through N store reads, the drain of the
// read and compare pipeline, the store write and the result load; the scan
// over the store's single read port makes this grow with N. The first number
// into an empty set skips the scan and drain, and a rejected item goes
// straight to the result load, which waits for the output register to be
// free. in_ready is low while an item is in progress; a finished result waits
// in the output register, and the next item may be accepted meanwhile. Write
// the capacity register only while the block is idle.

module set_min_max_gap_tracker_unit #(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sgt_pkg::CAP_BITS-1:0]   cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [31:0]             value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           status,
    output logic                           span_valid,
    output logic [sgt_pkg::SPAN_BITS-1:0]  shortest_span,
    output logic [sgt_pkg::SPAN_BITS-1:0]  longest_span,
    output logic [sgt_pkg::COUNT_BITS-1:0] count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    sgt_pkg::sgt_state_t state_reg, state_next;

    logic [sgt_pkg::CAP_BITS-1:0] cap_reg;
    logic [CW-1:0]                held_reg;
    logic [AW-1:0]                rd_idx_reg;
    logic                         sample_reg;
    logic [VALUE_BITS-1:0]        v_reg;
    logic [VALUE_BITS-1:0]        min_reg;
    logic [VALUE_BITS-1:0]        max_reg;
    logic                         reject_reg;

    logic                         out_valid_reg;
    logic                         status_reg;
    logic                         span_valid_reg;
    logic [sgt_pkg::SPAN_BITS-1:0]  shortest_reg;
    logic [sgt_pkg::SPAN_BITS-1:0]  longest_reg;
    logic [sgt_pkg::COUNT_BITS-1:0] count_reg;

    logic                  in_fire;
    logic                  has_room;
    logic [31:0]           held_wide;
    logic [31:0]           cap_wide;
    logic                  ram_we;
    logic                  ram_re;
    logic [VALUE_BITS-1:0] ram_rdata;
    logic                  gap_busy;
    logic [sgt_pkg::SPAN_BITS-1:0] gap;
    logic                  last_read;
    logic                  out_load;
    logic                  two_held;
    logic signed [VALUE_BITS:0] span_diff;

    assign in_ready  = (state_reg == sgt_pkg::S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign held_wide = 32'(held_reg);
    assign cap_wide  = 32'(cap_reg);
    assign has_room  = (held_wide < cap_wide) && (held_wide < 32'(CAPACITY));
    assign last_read = (CW'(rd_idx_reg) == (held_reg - CW'(1)));
    assign ram_re    = (state_reg == sgt_pkg::S_SCAN);
    assign ram_we    = (state_reg == sgt_pkg::S_WRITE);
    assign out_load  = (state_reg == sgt_pkg::S_FIN) && (!out_valid_reg || out_ready);
    assign two_held  = (held_wide >= 32'd2);
    assign span_diff = {max_reg[VALUE_BITS-1], max_reg} - {min_reg[VALUE_BITS-1], min_reg};

    sgt_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (held_reg[AW-1:0]),
        .wdata (v_reg),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    sgt_gap_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_gap (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_reg),
        .new_value (v_reg),
        .old_value (ram_rdata),
        .busy      (gap_busy),
        .gap       (gap)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sgt_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    if (!has_room)
                    begin
                        state_next = sgt_pkg::S_FIN;
                    end
                    else if (held_reg == '0)
                    begin
                        state_next = sgt_pkg::S_WRITE;
                    end
                    else
                    begin
                        state_next = sgt_pkg::S_SCAN;
                    end
                end
            end
            sgt_pkg::S_SCAN:
            begin
                if (last_read)
                begin
                    state_next = sgt_pkg::S_DRAIN;
                end
            end
            sgt_pkg::S_DRAIN:
            begin
                // wait for the last read and its compare to land in the gap register
                if (!sample_reg && !gap_busy)
                begin
                    state_next = sgt_pkg::S_WRITE;
                end
            end
            sgt_pkg::S_WRITE:
            begin
                state_next = sgt_pkg::S_FIN;
            end
            sgt_pkg::S_FIN:
            begin
                if (out_load)
                begin
                    state_next = sgt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sgt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sgt_pkg::S_IDLE;
            cap_reg       <= sgt_pkg::CAP_RESET;
            held_reg      <= '0;
            rd_idx_reg    <= '0;
            sample_reg    <= 1'b0;
            min_reg       <= '0;
            max_reg       <= '0;
            reject_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sample_reg <= ram_re;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (in_fire)
            begin
                rd_idx_reg <= '0;
                reject_reg <= !has_room;
            end
            else if (ram_re)
            begin
                rd_idx_reg <= rd_idx_reg + AW'(1);
            end
            if (ram_we)
            begin
                held_reg <= held_reg + CW'(1);
                if (held_reg == '0)
                begin
                    min_reg <= v_reg;
                    max_reg <= v_reg;
                end
                else
                begin
                    if ($signed(v_reg) < $signed(min_reg))
                    begin
                        min_reg <= v_reg;
                    end
                    if ($signed(v_reg) > $signed(max_reg))
                    begin
                        max_reg <= v_reg;
                    end
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            v_reg <= value[VALUE_BITS-1:0];
        end
        if (out_load)
        begin
            status_reg     <= reject_reg ? sgt_pkg::STATUS_FULL : sgt_pkg::STATUS_STORED;
            span_valid_reg <= two_held;
            shortest_reg   <= two_held ? gap : '0;
            longest_reg    <= two_held ? sgt_pkg::SPAN_BITS'(span_diff[VALUE_BITS-1:0]) : '0;
            count_reg      <= held_wide[sgt_pkg::COUNT_BITS-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign span_valid    = span_valid_reg;
    assign shortest_span = shortest_reg;
    assign longest_span  = longest_reg;
    assign count         = count_reg;

endmodule
